>>> hw/rtl/tsq_pkg.sv
// Shared types and constants for the touch sample qualifier.
// Holds the channel word structs, the stage control struct and register codes.
// No dependencies.
`default_nettype none

package tsq_pkg;

  // One input word: pen state, ADC sample and catch-clear request.
  typedef struct packed {
    logic        pen_down;
    logic [11:0] sample;
    logic        clear_catch;
  } tsq_in_t;

  // One result word.
  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic        pressed;
    logic        caught;
    logic        agreed;
  } tsq_out_t;

  // Control that travels with every word down the pipeline.
  typedef struct packed {
    logic       pen;
    logic       clr;
    logic       grp_done;
    logic [1:0] grp_idx;
    logic       agree;
  } tsq_ctl_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_RAW_MODE  = 3'd0,
    REG_X_GAIN    = 3'd1,
    REG_Y_GAIN    = 3'd2,
    REG_X_OFFSET  = 3'd3,
    REG_Y_OFFSET  = 3'd4,
    REG_AGREE_TOL = 3'd5
  } tsq_reg_t;

  // The scan is four groups: X, Y, X, Y.
  localparam logic [1:0] LAST_GROUP = 2'd3;

  // Fraction bits of the calibration gains.
  localparam int CAL_FRAC = 14;

  // Reset values of the configuration registers.
  localparam logic        RAW_MODE_RST  = 1'b0;
  localparam logic [15:0] X_GAIN_RST    = 16'hF7A3;
  localparam logic [15:0] Y_GAIN_RST    = 16'hFA3A;
  localparam logic [15:0] X_OFFSET_RST  = 16'd507;
  localparam logic [15:0] Y_OFFSET_RST  = 16'd315;
  localparam logic [11:0] AGREE_TOL_RST = 12'd50;

  // Position reported while no pen is present.
  localparam logic [15:0] POS_IDLE = 16'hFFFF;

endpackage

`default_nettype wire

>>> hw/rtl/tsq_accum.sv
// Group accumulator: running sum, minimum, maximum and sample count.
// Emits the trimmed group sum into the first pipeline register. Uses tsq_pkg.
`default_nettype none

module tsq_accum
  import tsq_pkg::*;
#(
  parameter int SAMPLES_PER_GROUP = 5,
  parameter int TRIM_EACH_SIDE    = 1,
  parameter int ADC_BITS          = 12,
  localparam int SumW  = $clog2(SAMPLES_PER_GROUP * ((1 << ADC_BITS) - 1) + 1),
  localparam int TrimW = $clog2((SAMPLES_PER_GROUP - 2 * TRIM_EACH_SIDE) *
                                ((1 << ADC_BITS) - 1) + 1),
  localparam int CntW  = $clog2(SAMPLES_PER_GROUP + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire tsq_in_t          in_data,
  input  wire logic             dn_ready,
  output      logic             dn_valid,
  output      tsq_ctl_t         dn_ctl,
  output      logic [TrimW-1:0] dn_trim
);

  logic [SumW-1:0]     sum_r;
  logic [ADC_BITS-1:0] min_r;
  logic [ADC_BITS-1:0] max_r;
  logic [CntW-1:0]     cnt_r;
  logic [1:0]          grp_r;
  logic                p1_valid_r;
  tsq_ctl_t            p1_ctl_r;
  logic [TrimW-1:0]    p1_trim_r;

  logic [ADC_BITS-1:0] smp;
  logic [SumW-1:0]     sum_nxt;
  logic [ADC_BITS-1:0] min_nxt;
  logic [ADC_BITS-1:0] max_nxt;
  logic [CntW-1:0]     cnt_nxt;
  logic                done;
  logic [SumW-1:0]     trim_full;
  logic                accept;

  // The stage takes a word when it is empty or its content moves on.
  assign in_ready = !p1_valid_r || dn_ready;
  assign accept   = in_valid && in_ready;

  // Fold the sample into the running group statistics.
  always_comb begin
    smp       = ADC_BITS'(in_data.sample);
    sum_nxt   = sum_r + SumW'(smp);
    min_nxt   = (smp < min_r) ? smp : min_r;
    max_nxt   = (smp > max_r) ? smp : max_r;
    cnt_nxt   = cnt_r + 1'b1;
    done      = (cnt_nxt == CntW'(SAMPLES_PER_GROUP));
    trim_full = sum_nxt - SumW'(min_nxt) - SumW'(max_nxt);
  end

  // Accumulator state; a pen-up word drops any partial scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      min_r <= '1;
      max_r <= '0;
      cnt_r <= '0;
      grp_r <= '0;
    end else if (accept) begin
      if (in_data.pen_down && !done) begin
        sum_r <= sum_nxt;
        min_r <= min_nxt;
        max_r <= max_nxt;
        cnt_r <= cnt_nxt;
      end else begin
        sum_r <= '0;
        min_r <= '1;
        max_r <= '0;
        cnt_r <= '0;
        if (!in_data.pen_down || grp_r == LAST_GROUP) begin
          grp_r <= '0;
        end else begin
          grp_r <= grp_r + 2'd1;
        end
      end
    end
  end

  // First pipeline register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_ready) begin
      p1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_ctl_r.pen      <= in_data.pen_down;
      p1_ctl_r.clr      <= in_data.clear_catch;
      p1_ctl_r.grp_done <= in_data.pen_down && done;
      p1_ctl_r.grp_idx  <= grp_r;
      p1_ctl_r.agree    <= 1'b0;
      p1_trim_r         <= TrimW'(trim_full);
    end
  end

  assign dn_valid = p1_valid_r;
  assign dn_ctl   = p1_ctl_r;
  assign dn_trim  = p1_trim_r;

endmodule

`default_nettype wire

>>> hw/rtl/tsq_mean.sv
// Trimmed mean by reciprocal multiply, storage of the first three means and
// the agreement check with pair averaging. Two register stages. Uses tsq_pkg.
`default_nettype none

module tsq_mean
  import tsq_pkg::*;
#(
  parameter int SAMPLES_PER_GROUP = 5,
  parameter int TRIM_EACH_SIDE    = 1,
  parameter int ADC_BITS          = 12,
  localparam int Div    = SAMPLES_PER_GROUP - 2 * TRIM_EACH_SIDE,
  localparam int TrimW  = $clog2(Div * ((1 << ADC_BITS) - 1) + 1),
  localparam int Shift  = TrimW + $clog2(Div),
  localparam int Recip  = ((1 << Shift) + Div - 1) / Div,
  localparam int RecW   = Shift + 1,
  localparam int ProdW  = TrimW + RecW,
  localparam int CmpW   = (ADC_BITS > 12) ? ADC_BITS : 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [11:0]         agree_tol,
  input  wire logic                up_valid,
  output      logic                up_ready,
  input  wire tsq_ctl_t            up_ctl,
  input  wire logic [TrimW-1:0]    up_trim,
  input  wire logic                dn_ready,
  output      logic                dn_valid,
  output      tsq_ctl_t            dn_ctl,
  output      logic [ADC_BITS-1:0] dn_ax,
  output      logic [ADC_BITS-1:0] dn_ay
);

  localparam logic [RecW-1:0] RecipC = RecW'(Recip);

  logic [ADC_BITS-1:0] fm_r [3];
  logic                p2_valid_r;
  tsq_ctl_t            p2_ctl_r;
  logic [ADC_BITS-1:0] p2_mean_r;
  logic                p3_valid_r;
  tsq_ctl_t            p3_ctl_r;
  logic [ADC_BITS-1:0] p3_ax_r;
  logic [ADC_BITS-1:0] p3_ay_r;

  logic [ProdW-1:0]    prod;
  logic [ADC_BITS-1:0] mean_nxt;
  logic                ready2;
  logic [ADC_BITS-1:0] dx;
  logic [ADC_BITS-1:0] dy;
  logic [ADC_BITS:0]   sx;
  logic [ADC_BITS:0]   sy;
  logic                agree_nxt;
  tsq_ctl_t            ctl3_nxt;

  assign ready2   = !p3_valid_r || dn_ready;
  assign up_ready = !p2_valid_r || ready2;

  // Division by the trimmed count as a multiply by a rounded-up reciprocal.
  always_comb begin
    prod     = ProdW'(up_trim) * ProdW'(RecipC);
    mean_nxt = ADC_BITS'(prod >> Shift);
  end

  // Second pipeline register and the store of the first three means.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (up_ready) begin
      p2_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      p2_ctl_r  <= up_ctl;
      p2_mean_r <= mean_nxt;
      if (up_ctl.grp_done && up_ctl.grp_idx != LAST_GROUP) begin
        fm_r[up_ctl.grp_idx] <= mean_nxt;
      end
    end
  end

  // Compare the two X means and the two Y means, and average each pair.
  always_comb begin
    dx        = (fm_r[0] > fm_r[2]) ? fm_r[0] - fm_r[2] : fm_r[2] - fm_r[0];
    dy        = (fm_r[1] > p2_mean_r) ? fm_r[1] - p2_mean_r : p2_mean_r - fm_r[1];
    agree_nxt = (CmpW'(dx) < CmpW'(agree_tol)) && (CmpW'(dy) < CmpW'(agree_tol));
    sx        = {1'b0, fm_r[0]} + {1'b0, fm_r[2]};
    sy        = {1'b0, fm_r[1]} + {1'b0, p2_mean_r};
    ctl3_nxt       = p2_ctl_r;
    ctl3_nxt.agree = agree_nxt;
  end

  // Third pipeline register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (ready2) begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && p2_valid_r) begin
      p3_ctl_r <= ctl3_nxt;
      p3_ax_r  <= sx[ADC_BITS:1];
      p3_ay_r  <= sy[ADC_BITS:1];
    end
  end

  assign dn_valid = p3_valid_r;
  assign dn_ctl   = p3_ctl_r;
  assign dn_ax    = p3_ax_r;
  assign dn_ay    = p3_ay_r;

endmodule

`default_nettype wire

>>> hw/rtl/tsq_calib.sv
// Calibration: signed gain products in a register stage, then offset add,
// truncation and saturation to 0..65535 on the registered products. Uses tsq_pkg.
`default_nettype none

module tsq_calib
  import tsq_pkg::*;
#(
  parameter int ADC_BITS = 12,
  localparam int ProdW = ADC_BITS + 17,
  localparam int CalW  = ((ProdW > 16 + CAL_FRAC) ? ProdW : 16 + CAL_FRAC) + 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [15:0]         x_gain,
  input  wire logic [15:0]         y_gain,
  input  wire logic [15:0]         x_offset,
  input  wire logic [15:0]         y_offset,
  input  wire logic                up_valid,
  output      logic                up_ready,
  input  wire tsq_ctl_t            up_ctl,
  input  wire logic [ADC_BITS-1:0] up_ax,
  input  wire logic [ADC_BITS-1:0] up_ay,
  input  wire logic                dn_ready,
  output      logic                dn_valid,
  output      tsq_ctl_t            dn_ctl,
  output      logic [ADC_BITS-1:0] dn_ax,
  output      logic [ADC_BITS-1:0] dn_ay,
  output      logic [15:0]         cal_x,
  output      logic [15:0]         cal_y
);

  logic                    p4_valid_r;
  tsq_ctl_t                p4_ctl_r;
  logic [ADC_BITS-1:0]     p4_ax_r;
  logic [ADC_BITS-1:0]     p4_ay_r;
  logic signed [ProdW-1:0] p4_px_r;
  logic signed [ProdW-1:0] p4_py_r;

  logic signed [ProdW-1:0] px_nxt;
  logic signed [ProdW-1:0] py_nxt;

  // Offset in Q14, add, clamp negatives to zero and large values to full scale.
  function automatic logic [15:0] sat_cal(input logic signed [ProdW-1:0] p,
                                          input logic [15:0] off);
    logic signed [CalW-1:0] t;
    logic [15:0]            res;
    t = CalW'(p) + (CalW'($signed(off)) <<< CAL_FRAC);
    if (t[CalW-1]) begin
      res = '0;
    end else if (|t[CalW-1:CAL_FRAC+16]) begin
      res = '1;
    end else begin
      res = t[CAL_FRAC+15:CAL_FRAC];
    end
    return res;
  endfunction

  assign up_ready = !p4_valid_r || dn_ready;

  // Screen X comes from the raw Y average and screen Y from the raw X average.
  always_comb begin
    px_nxt = ProdW'($signed(x_gain)) * $signed({1'b0, up_ay});
    py_nxt = ProdW'($signed(y_gain)) * $signed({1'b0, up_ax});
  end

  // Fourth pipeline register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_valid_r <= 1'b0;
    end else if (up_ready) begin
      p4_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      p4_ctl_r <= up_ctl;
      p4_ax_r  <= up_ax;
      p4_ay_r  <= up_ay;
      p4_px_r  <= px_nxt;
      p4_py_r  <= py_nxt;
    end
  end

  assign dn_valid = p4_valid_r;
  assign dn_ctl   = p4_ctl_r;
  assign dn_ax    = p4_ax_r;
  assign dn_ay    = p4_ay_r;
  assign cal_x    = sat_cal(p4_px_r, x_offset);
  assign cal_y    = sat_cal(p4_py_r, y_offset);

endmodule

`default_nettype wire

>>> hw/rtl/touch_sample_qualifier_unit.sv
// Touch sample qualifier: trimmed-mean filter over X, Y, X, Y sample groups,
// two-reading agreement, calibration and press tracking.
//
// Channels: in_* carries one word per ADC tick (pen state, sample, catch
// clear), out_* carries result words, cfg_* writes the six configuration
// registers by index and is always ready. All use valid/ready; a word moves
// on a clock edge where both are high.
// A pen-down word that closes the fourth group of a scan gives one result,
// every pen-up word gives one result, other words give none.
// A result is registered by each stage in turn, last in the output register.
// Throughput: one input word per cycle, set by the five-stage pipeline
// (accumulate, reciprocal multiply, agreement, gain multiply, saturate and
// update). Words that give no result leave the last stage even while a result
// waits in the output register, so the input keeps flowing until a pending
// result is blocked behind it.
// Reset (rst_n low, synchronous): configuration returns to its defaults,
// accumulators clear, the position reads 65535 each and the flags clear.
// A stalled receiver holds the output word steady until taken.
`default_nettype none

module touch_sample_qualifier_unit
  import tsq_pkg::*;
#(
  parameter int SAMPLES_PER_GROUP = 5,
  parameter int TRIM_EACH_SIDE    = 1,
  parameter int ADC_BITS          = 12,
  localparam int TrimW = $clog2((SAMPLES_PER_GROUP - 2 * TRIM_EACH_SIDE) *
                                ((1 << ADC_BITS) - 1) + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire tsq_in_t     in_data,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      tsq_out_t    out_data,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers.
  logic        raw_mode_r;
  logic [15:0] x_gain_r;
  logic [15:0] y_gain_r;
  logic [15:0] x_offset_r;
  logic [15:0] y_offset_r;
  logic [11:0] agree_tol_r;

  // Tracking state and output register.
  logic [15:0] pos_x_r;
  logic [15:0] pos_y_r;
  logic [15:0] start_x_r;
  logic [15:0] start_y_r;
  logic        pressed_r;
  logic        caught_r;
  logic        out_valid_r;
  tsq_out_t    out_data_r;

  // Pipeline links.
  logic                v1;
  logic                r1;
  tsq_ctl_t            c1;
  logic [TrimW-1:0]    trim1;
  logic                v3;
  logic                r3;
  tsq_ctl_t            c3;
  logic [ADC_BITS-1:0] ax3;
  logic [ADC_BITS-1:0] ay3;
  logic                v4;
  logic                r4;
  tsq_ctl_t            c4;
  logic [ADC_BITS-1:0] ax4;
  logic [ADC_BITS-1:0] ay4;
  logic [15:0]         cal_x;
  logic [15:0]         cal_y;

  // Next-state values for the last stage.
  logic        is_last;
  logic        emit;
  logic        fire;
  logic [15:0] pos_x_nxt;
  logic [15:0] pos_y_nxt;
  logic [15:0] start_x_nxt;
  logic [15:0] start_y_nxt;
  logic        pressed_nxt;
  logic        caught_nxt;
  logic        agreed_nxt;
  tsq_out_t    word_nxt;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r  <= RAW_MODE_RST;
      x_gain_r    <= X_GAIN_RST;
      y_gain_r    <= Y_GAIN_RST;
      x_offset_r  <= X_OFFSET_RST;
      y_offset_r  <= Y_OFFSET_RST;
      agree_tol_r <= AGREE_TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (tsq_reg_t'(cfg_addr))
        REG_RAW_MODE:  raw_mode_r  <= cfg_data[0];
        REG_X_GAIN:    x_gain_r    <= cfg_data;
        REG_Y_GAIN:    y_gain_r    <= cfg_data;
        REG_X_OFFSET:  x_offset_r  <= cfg_data;
        REG_Y_OFFSET:  y_offset_r  <= cfg_data;
        REG_AGREE_TOL: agree_tol_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  tsq_accum #(
    .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
    .TRIM_EACH_SIDE    (TRIM_EACH_SIDE),
    .ADC_BITS          (ADC_BITS)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dn_ready (r1),
    .dn_valid (v1),
    .dn_ctl   (c1),
    .dn_trim  (trim1)
  );

  tsq_mean #(
    .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
    .TRIM_EACH_SIDE    (TRIM_EACH_SIDE),
    .ADC_BITS          (ADC_BITS)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .agree_tol (agree_tol_r),
    .up_valid  (v1),
    .up_ready  (r1),
    .up_ctl    (c1),
    .up_trim   (trim1),
    .dn_ready  (r3),
    .dn_valid  (v3),
    .dn_ctl    (c3),
    .dn_ax     (ax3),
    .dn_ay     (ay3)
  );

  tsq_calib #(
    .ADC_BITS (ADC_BITS)
  ) u_calib (
    .clk      (clk),
    .rst_n    (rst_n),
    .x_gain   (x_gain_r),
    .y_gain   (y_gain_r),
    .x_offset (x_offset_r),
    .y_offset (y_offset_r),
    .up_valid (v3),
    .up_ready (r3),
    .up_ctl   (c3),
    .up_ax    (ax3),
    .up_ay    (ay3),
    .dn_ready (r4),
    .dn_valid (v4),
    .dn_ctl   (c4),
    .dn_ax    (ax4),
    .dn_ay    (ay4),
    .cal_x    (cal_x),
    .cal_y    (cal_y)
  );

  // A word with no result may always leave; a result needs a free output slot.
  assign is_last = c4.grp_done && (c4.grp_idx == LAST_GROUP);
  assign emit    = !c4.pen || is_last;
  assign r4      = !emit || !out_valid_r || out_ready;
  assign fire    = v4 && r4;

  // Position, press-start and flag updates for the word in the last stage.
  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    pressed_nxt = pressed_r;
    caught_nxt  = caught_r;
    agreed_nxt  = 1'b0;
    if (!c4.pen) begin
      if (pressed_r) begin
        pressed_nxt = 1'b0;
      end else begin
        start_x_nxt = '0;
        start_y_nxt = '0;
        pos_x_nxt   = POS_IDLE;
        pos_y_nxt   = POS_IDLE;
      end
    end else if (is_last) begin
      if (c4.agree) begin
        agreed_nxt = 1'b1;
        if (raw_mode_r) begin
          pos_x_nxt = 16'(ax4);
          pos_y_nxt = 16'(ay4);
        end else begin
          pos_x_nxt = cal_x;
          pos_y_nxt = cal_y;
        end
      end
      if (!pressed_r) begin
        pressed_nxt = 1'b1;
        caught_nxt  = 1'b1;
        start_x_nxt = pos_x_nxt;
        start_y_nxt = pos_y_nxt;
      end
    end
    word_nxt.pos_x   = pos_x_nxt;
    word_nxt.pos_y   = pos_y_nxt;
    word_nxt.start_x = start_x_nxt;
    word_nxt.start_y = start_y_nxt;
    word_nxt.pressed = pressed_nxt;
    word_nxt.caught  = caught_nxt;
    word_nxt.agreed  = agreed_nxt;
  end

  // Tracking state; the catch clear lands after the result is formed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= POS_IDLE;
      pos_y_r   <= POS_IDLE;
      start_x_r <= '0;
      start_y_r <= '0;
      pressed_r <= 1'b0;
      caught_r  <= 1'b0;
    end else if (fire) begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
      pressed_r <= pressed_nxt;
      caught_r  <= caught_nxt && !c4.clr;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_data_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
